FILE: rtl/tmse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmse_pkg
// Shared types and constants of the Turing machine step engine: payload
// words, configuration bundle, rule layout, codes and controller interface.
// ----------------------------------------------------------------------------
package tmse_pkg;

	localparam int STATE_BITS      = 8;
	localparam int SYMBOL_BITS     = 8;
	localparam int HEAD_BITS       = 10;
	localparam int STEP_BITS       = 32;
	localparam int RULES_USED_BITS = 7;
	localparam int SLOT_IDX_BITS   = 6;
	localparam int MOVE_BITS       = 2;
	localparam int APB_AW          = 4;
	localparam int APB_DW          = 32;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_START = 2'd1,
		OP_STEP  = 2'd2,
		OP_READ  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_STEP   = 2'd0,
		ST_FINAL  = 2'd1,
		ST_NORULE = 2'd2,
		ST_DONE   = 2'd3
	} status_t;

	localparam logic [MOVE_BITS-1:0] MOVE_STAY     = 2'd0;
	localparam logic [MOVE_BITS-1:0] MOVE_LEFT     = 2'd1;
	localparam logic [MOVE_BITS-1:0] MOVE_RIGHT    = 2'd2;
	localparam logic [MOVE_BITS-1:0] MOVE_STAY_ALT = 2'd3;

	localparam logic [1:0] REG_INIT_STATE  = 2'd0;
	localparam logic [1:0] REG_FINAL_STATE = 2'd1;
	localparam logic [1:0] REG_INIT_POS    = 2'd2;
	localparam logic [1:0] REG_RULES_USED  = 2'd3;

	typedef enum logic [2:0] {
		S_RST_CLR,
		S_IDLE,
		S_READ,
		S_SEARCH,
		S_START_CLR,
		S_REPLY
	} fsm_t;

	typedef struct packed {
		logic [1:0]               opcode;
		logic [SLOT_IDX_BITS-1:0] rule_index;
		logic [STATE_BITS-1:0]    rule_state;
		logic [SYMBOL_BITS-1:0]   rule_scan;
		logic [SYMBOL_BITS-1:0]   rule_write;
		logic [MOVE_BITS-1:0]     rule_move;
		logic [STATE_BITS-1:0]    rule_next;
		logic [HEAD_BITS-1:0]     tape_addr;
	} in_t;

	typedef struct packed {
		logic [1:0]             status;
		logic                   edge_blocked;
		logic [STATE_BITS-1:0]  machine_state_out;
		logic [HEAD_BITS-1:0]   head_out;
		logic [STEP_BITS-1:0]   steps_out;
		logic [SYMBOL_BITS-1:0] cell_value;
	} out_t;

	typedef struct packed {
		logic [STATE_BITS-1:0]      initial_state;
		logic [STATE_BITS-1:0]      final_state;
		logic [HEAD_BITS-1:0]       initial_position;
		logic [RULES_USED_BITS-1:0] rules_used;
	} cfg_t;

	typedef struct packed {
		logic [STATE_BITS-1:0]  match_state;
		logic [SYMBOL_BITS-1:0] match_scan;
		logic [SYMBOL_BITS-1:0] write_sym;
		logic [MOVE_BITS-1:0]   move;
		logic [STATE_BITS-1:0]  next_state;
	} rule_t;

	// controller -> datapath
	typedef struct packed {
		logic    accept;
		logic    load_rule;
		logic    start_init;
		logic    step_begin;
		logic    read_begin;
		logic    read_latch;
		logic    clr_run;
		logic    advance;
		logic    apply;
		logic    code_we;
		status_t code;
		logic    out_load;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic exhausted;
		logic hit;
		logic at_final;
	} stat_t;

endpackage

FILE: rtl/tmse_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tmse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/tmse_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmse_ctrl
// Sequencer of the step engine: tape clearing, command dispatch, rule search
// and the result register handshake.
// ----------------------------------------------------------------------------
module tmse_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  logic [1:0]      opcode,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	input  tmse_pkg::stat_t stat,
	output tmse_pkg::ctl_t  ctl
);

	tmse_pkg::fsm_t state_q, state_d;
	logic           rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tmse_pkg::S_RST_CLR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		ctl.code  = tmse_pkg::ST_DONE;
		cmd_stall = 1'b1;
		case (state_q)
			tmse_pkg::S_RST_CLR: begin
				ctl.clr_run = 1'b1;
				if (stat.clr_last) begin
					state_d = tmse_pkg::S_IDLE;
				end
			end
			tmse_pkg::S_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					ctl.accept = 1'b1;
					case (opcode)
						tmse_pkg::OP_LOAD: begin
							ctl.load_rule = 1'b1;
							state_d       = tmse_pkg::S_REPLY;
						end
						tmse_pkg::OP_START: begin
							ctl.start_init = 1'b1;
							state_d        = tmse_pkg::S_START_CLR;
						end
						tmse_pkg::OP_STEP: begin
							ctl.step_begin = 1'b1;
							state_d        = tmse_pkg::S_SEARCH;
						end
						tmse_pkg::OP_READ: begin
							ctl.read_begin = 1'b1;
							state_d        = tmse_pkg::S_READ;
						end
						default: begin
							state_d = tmse_pkg::S_REPLY;
						end
					endcase
				end
			end
			tmse_pkg::S_READ: begin
				ctl.read_latch = 1'b1;
				state_d        = tmse_pkg::S_REPLY;
			end
			tmse_pkg::S_SEARCH: begin
				if (stat.exhausted) begin
					ctl.code_we = 1'b1;
					ctl.code    = stat.at_final ? tmse_pkg::ST_FINAL : tmse_pkg::ST_NORULE;
					state_d     = tmse_pkg::S_REPLY;
				end else if (stat.hit) begin
					ctl.apply = 1'b1;
					state_d   = tmse_pkg::S_REPLY;
				end else begin
					// try the next slot
					ctl.advance = 1'b1;
				end
			end
			tmse_pkg::S_START_CLR: begin
				ctl.clr_run = 1'b1;
				if (stat.clr_last) begin
					state_d = tmse_pkg::S_REPLY;
				end
			end
			tmse_pkg::S_REPLY: begin
				// hold until the result register is free
				if (!rsp_valid_q || !rsp_stall) begin
					ctl.out_load = 1'b1;
					state_d      = tmse_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tmse_pkg::S_RST_CLR;
			end
		endcase
	end

endmodule

FILE: rtl/tmse_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmse_dp
// Datapath of the step engine: tape and rule memories, machine registers,
// rule matcher, head mover and result register.
// ----------------------------------------------------------------------------
module tmse_dp #(
	parameter int TAPE_CELLS = 1024,
	parameter int RULE_SLOTS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tmse_pkg::ctl_t  ctl,
	output tmse_pkg::stat_t stat,
	input  tmse_pkg::in_t   cmd,
	input  tmse_pkg::cfg_t  cfg,
	output tmse_pkg::out_t  rsp
);

	localparam int TAW = (TAPE_CELLS > 1) ? $clog2(TAPE_CELLS) : 1;
	localparam int RIW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
	localparam int RCW = $clog2(RULE_SLOTS + 1);
	localparam int RULE_BITS = $bits(tmse_pkg::rule_t);

	logic [tmse_pkg::STATE_BITS-1:0]  state_q;
	logic [TAW-1:0]                   head_q;
	logic [tmse_pkg::STEP_BITS-1:0]   steps_q;
	logic [TAW-1:0]                   clr_q;
	logic [RCW-1:0]                   slot_q;
	tmse_pkg::status_t                status_q;
	logic                             edge_q;
	logic [tmse_pkg::SYMBOL_BITS-1:0] cell_q;
	logic                             rd_oob_q;
	tmse_pkg::out_t                   rsp_q;

	logic                             tape_we;
	logic [TAW-1:0]                   tape_waddr;
	logic [tmse_pkg::SYMBOL_BITS-1:0] tape_wdata;
	logic                             tape_re;
	logic [TAW-1:0]                   tape_raddr;
	logic [tmse_pkg::SYMBOL_BITS-1:0] tape_rd;

	logic                             rule_we;
	logic [RIW-1:0]                   rule_waddr;
	tmse_pkg::rule_t                  rule_wdata;
	logic                             rule_re;
	logic [RIW-1:0]                   rule_raddr;
	logic [RULE_BITS-1:0]             rule_rdata;
	tmse_pkg::rule_t                  rule_q;

	logic           rd_in_range;
	logic           init_in_range;
	logic [RCW-1:0] slot_next;
	logic [RIW-1:0] slot_next_idx;
	logic           move_blocked;
	logic [TAW-1:0] head_moved;

	assign rd_in_range   = 32'(cmd.tape_addr) < TAPE_CELLS;
	assign init_in_range = 32'(cfg.initial_position) < TAPE_CELLS;

	// tape: clear sweep, rule write-back, head or address reads
	assign tape_we    = ctl.clr_run | ctl.apply;
	assign tape_waddr = ctl.clr_run ? clr_q : head_q;
	assign tape_wdata = ctl.clr_run ? '0 : rule_q.write_sym;
	assign tape_re    = ctl.step_begin | ctl.read_begin;
	assign tape_raddr = ctl.read_begin ? (rd_in_range ? TAW'(cmd.tape_addr) : '0) : head_q;

	tmse_ram #(
		.WIDTH(tmse_pkg::SYMBOL_BITS),
		.DEPTH(TAPE_CELLS)
	) u_tape (
		.clk  (clk),
		.we   (tape_we),
		.waddr(tape_waddr),
		.wdata(tape_wdata),
		.re   (tape_re),
		.raddr(tape_raddr),
		.rdata(tape_rd)
	);

	assign rule_we    = ctl.load_rule && (32'(cmd.rule_index) < RULE_SLOTS);
	assign rule_waddr = RIW'(cmd.rule_index);
	assign rule_wdata = '{
		match_state: cmd.rule_state,
		match_scan:  cmd.rule_scan,
		write_sym:   cmd.rule_write,
		move:        cmd.rule_move,
		next_state:  cmd.rule_next
	};

	assign slot_next     = slot_q + RCW'(1);
	assign slot_next_idx = (32'(slot_next) < RULE_SLOTS) ? RIW'(slot_next) : '0;
	assign rule_re       = ctl.step_begin | ctl.advance;
	assign rule_raddr    = ctl.step_begin ? '0 : slot_next_idx;

	tmse_ram #(
		.WIDTH(RULE_BITS),
		.DEPTH(RULE_SLOTS)
	) u_rules (
		.clk  (clk),
		.we   (rule_we),
		.waddr(rule_waddr),
		.wdata(rule_wdata),
		.re   (rule_re),
		.raddr(rule_raddr),
		.rdata(rule_rdata)
	);

	assign rule_q = tmse_pkg::rule_t'(rule_rdata);

	always_comb begin
		stat.clr_last  = 32'(clr_q) == (TAPE_CELLS - 1);
		stat.exhausted = (32'(slot_q) >= 32'(cfg.rules_used)) || (32'(slot_q) >= RULE_SLOTS);
		stat.hit       = !stat.exhausted && (rule_q.match_state == state_q)
		                 && (rule_q.match_scan == tape_rd);
		stat.at_final  = state_q == cfg.final_state;
	end

	always_comb begin
		move_blocked = 1'b0;
		head_moved   = head_q;
		case (rule_q.move)
			tmse_pkg::MOVE_LEFT: begin
				if (head_q == '0) begin
					move_blocked = 1'b1;
				end else begin
					head_moved = head_q - TAW'(1);
				end
			end
			tmse_pkg::MOVE_RIGHT: begin
				if (32'(head_q) == (TAPE_CELLS - 1)) begin
					move_blocked = 1'b1;
				end else begin
					head_moved = head_q + TAW'(1);
				end
			end
			default: begin
				head_moved = head_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			head_q  <= '0;
			steps_q <= '0;
			clr_q   <= '0;
			slot_q  <= '0;
		end else begin
			if (ctl.clr_run) begin
				clr_q <= stat.clr_last ? '0 : clr_q + TAW'(1);
			end
			if (ctl.step_begin) begin
				slot_q <= '0;
			end else if (ctl.advance) begin
				slot_q <= slot_next;
			end
			if (ctl.start_init) begin
				state_q <= cfg.initial_state;
				steps_q <= '0;
				if (init_in_range) begin
					head_q <= TAW'(cfg.initial_position);
				end
			end
			if (ctl.apply) begin
				state_q <= rule_q.next_state;
				head_q  <= head_moved;
				if (steps_q != '1) begin
					steps_q <= steps_q + 32'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			status_q <= tmse_pkg::ST_DONE;
			// flag a start whose head placement falls off the tape
			edge_q   <= ctl.start_init && !init_in_range;
			cell_q   <= '0;
			rd_oob_q <= !rd_in_range;
		end
		if (ctl.read_latch) begin
			cell_q <= rd_oob_q ? '0 : tape_rd;
		end
		if (ctl.apply) begin
			status_q <= tmse_pkg::ST_STEP;
			edge_q   <= move_blocked;
		end
		if (ctl.code_we) begin
			status_q <= ctl.code;
		end
		if (ctl.out_load) begin
			rsp_q.status            <= status_q;
			rsp_q.edge_blocked      <= edge_q;
			rsp_q.machine_state_out <= state_q;
			rsp_q.head_out          <= tmse_pkg::HEAD_BITS'(head_q);
			rsp_q.steps_out         <= steps_q;
			rsp_q.cell_value        <= cell_q;
		end
	end

	assign rsp = rsp_q;

endmodule

FILE: rtl/turing_machine_step_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turing_machine_step_engine
// Single-tape Turing machine: rule loading, start, single steps, tape reads.
// ----------------------------------------------------------------------------
// Usage:
//   Command words enter on cmd/cmd_valid/cmd_stall, one result word per
//   command leaves on rsp/rsp_valid/rsp_stall; one command is in work at a time.
//   A start clears the tape one cell per cycle; a step searches the rule
//   slots from slot 0 upward up to the first match, or through
//   min(rules_used, RULE_SLOTS) slots on a miss. The next command can be
//   taken in the cycle after the result is loaded. After reset the tape is
//   cleared in a sweep over all TAPE_CELLS cells with cmd_stall high; APB
//   register writes are taken throughout.
//   A finished result waits in the output register while rsp_stall is high;
//   the engine still accepts the next command and holds its own result
//   until the register frees up.
//   Registers (APB, pready always high): 0x0 initial_state, 0x4 final_state,
//   0x8 initial_position, 0xC rules_used. Write them only while idle.
// ----------------------------------------------------------------------------
module turing_machine_step_engine #(
	parameter int TAPE_CELLS = 1024,
	parameter int RULE_SLOTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  tmse_pkg::in_t                 cmd,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output tmse_pkg::out_t                rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tmse_pkg::APB_AW-1:0]   paddr,
	input  logic [tmse_pkg::APB_DW-1:0]   pwdata,
	output logic [tmse_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	tmse_pkg::cfg_t  cfg_q;
	tmse_pkg::ctl_t  ctl;
	tmse_pkg::stat_t stat;
	logic            cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				tmse_pkg::REG_INIT_STATE:  cfg_q.initial_state    <= pwdata[tmse_pkg::STATE_BITS-1:0];
				tmse_pkg::REG_FINAL_STATE: cfg_q.final_state      <= pwdata[tmse_pkg::STATE_BITS-1:0];
				tmse_pkg::REG_INIT_POS:    cfg_q.initial_position <= pwdata[tmse_pkg::HEAD_BITS-1:0];
				tmse_pkg::REG_RULES_USED:  cfg_q.rules_used       <= pwdata[tmse_pkg::RULES_USED_BITS-1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			tmse_pkg::REG_INIT_STATE:  prdata = tmse_pkg::APB_DW'(cfg_q.initial_state);
			tmse_pkg::REG_FINAL_STATE: prdata = tmse_pkg::APB_DW'(cfg_q.final_state);
			tmse_pkg::REG_INIT_POS:    prdata = tmse_pkg::APB_DW'(cfg_q.initial_position);
			tmse_pkg::REG_RULES_USED:  prdata = tmse_pkg::APB_DW'(cfg_q.rules_used);
			default:                   prdata = '0;
		endcase
	end

	tmse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.opcode   (cmd.opcode),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.stat     (stat),
		.ctl      (ctl)
	);

	tmse_dp #(
		.TAPE_CELLS(TAPE_CELLS),
		.RULE_SLOTS(RULE_SLOTS)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.stat  (stat),
		.cmd   (cmd),
		.cfg   (cfg_q),
		.rsp   (rsp)
	);

`ifndef SYNTHESIS
	a_head_on_tape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(rsp.head_out) < TAPE_CELLS))
		else $error("head outside the tape");

	a_step_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.status == tmse_pkg::ST_STEP)) |-> (rsp.steps_out != '0))
		else $error("step taken with zero step count");

	a_cell_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.cell_value != '0)) |-> (rsp.status == tmse_pkg::ST_DONE))
		else $error("cell value on a non-read result");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> cmd_stall)
		else $error("second command taken while busy");
`endif

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Turing machine step engine. Command words come
// from a backlog that the stimulus process fills: directed programs first,
// then random rule tables with start, step and read runs. An in-bench
// machine model predicts every reply word at command acceptance; the monitor
// compares each reply field by field. Both handshakes idle at random by phase.
// ----------------------------------------------------------------------------
module tb;

	localparam int TAPE_CELLS = 1024;
	localparam int RULE_SLOTS = 64;
	localparam int HOLD_CYCLES = 400;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cmd_valid = 1'b0;
	logic                          cmd_stall;
	tmse_pkg::in_t                 cmd = '0;
	logic                          rsp_valid;
	logic                          rsp_stall = 1'b0;
	tmse_pkg::out_t                rsp;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [tmse_pkg::APB_AW-1:0]   paddr = '0;
	logic [tmse_pkg::APB_DW-1:0]   pwdata = '0;
	logic [tmse_pkg::APB_DW-1:0]   prdata;
	logic                          pready;

	// machine model
	logic [tmse_pkg::SYMBOL_BITS-1:0]     tape_cells [TAPE_CELLS];
	tmse_pkg::rule_t                      rule_slots [RULE_SLOTS];
	logic [tmse_pkg::STATE_BITS-1:0]      cur_state = '0;
	logic [tmse_pkg::HEAD_BITS-1:0]       cur_head = '0;
	logic [tmse_pkg::STEP_BITS-1:0]       step_total = '0;
	logic [tmse_pkg::STATE_BITS-1:0]      cfg_init_state = '0;
	logic [tmse_pkg::STATE_BITS-1:0]      cfg_final_state = '0;
	logic [tmse_pkg::HEAD_BITS-1:0]       cfg_init_pos = '0;
	logic [tmse_pkg::RULES_USED_BITS-1:0] cfg_rules_used = '0;

	tmse_pkg::out_t awaited_replies [$];
	tmse_pkg::in_t  cmd_backlog [$];
	bit   slot_filled [RULE_SLOTS];
	int   cmds_queued = 0;
	int   replies_seen = 0;
	int   bad_replies = 0;
	int   send_gap_pct = 0;
	int   stall_pct = 0;
	logic hold_start = 1'b0;
	int   hold_left = 0;

	turing_machine_step_engine #(
		.TAPE_CELLS(TAPE_CELLS),
		.RULE_SLOTS(RULE_SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		foreach (tape_cells[i]) tape_cells[i] = '0;
	end

	task automatic advance_machine(input tmse_pkg::in_t w);
		tmse_pkg::out_t  r;
		tmse_pkg::rule_t sel;
		int              lim;
		bit              hit;
		r = '0;
		hit = 1'b0;
		case (tmse_pkg::opcode_t'(w.opcode))
			tmse_pkg::OP_LOAD: begin
				rule_slots[w.rule_index] = '{w.rule_state, w.rule_scan, w.rule_write,
					w.rule_move, w.rule_next};
				r.status = tmse_pkg::ST_DONE;
			end
			tmse_pkg::OP_START: begin
				foreach (tape_cells[i]) tape_cells[i] = '0;
				cur_state = cfg_init_state;
				step_total = '0;
				cur_head = cfg_init_pos;
				r.status = tmse_pkg::ST_DONE;
			end
			tmse_pkg::OP_READ: begin
				r.cell_value = tape_cells[w.tape_addr];
				r.status = tmse_pkg::ST_DONE;
			end
			default: begin
				lim = (cfg_rules_used > RULE_SLOTS) ? RULE_SLOTS : int'(cfg_rules_used);
				for (int k = 0; k < lim && !hit; k++) begin
					if (rule_slots[k].match_state == cur_state &&
							rule_slots[k].match_scan == tape_cells[cur_head]) begin
						hit = 1'b1;
						sel = rule_slots[k];
					end
				end
				if (hit) begin
					tape_cells[cur_head] = sel.write_sym;
					if (sel.move == tmse_pkg::MOVE_LEFT) begin
						if (cur_head == '0) r.edge_blocked = 1'b1;
						else cur_head = cur_head - 10'd1;
					end else if (sel.move == tmse_pkg::MOVE_RIGHT) begin
						if (int'(cur_head) + 1 >= TAPE_CELLS) r.edge_blocked = 1'b1;
						else cur_head = cur_head + 10'd1;
					end
					cur_state = sel.next_state;
					if (step_total != '1) step_total = step_total + 32'd1;
					r.status = tmse_pkg::ST_STEP;
				end else begin
					r.status = (cur_state == cfg_final_state) ? tmse_pkg::ST_FINAL
						: tmse_pkg::ST_NORULE;
				end
			end
		endcase
		r.machine_state_out = cur_state;
		r.head_out = cur_head;
		r.steps_out = step_total;
		awaited_replies.push_back(r);
	endtask

	// command driver: predict at acceptance, then offer the next word
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else begin
			if (cmd_valid && !cmd_stall) advance_machine(cmd);
			if (!cmd_valid || !cmd_stall) begin
				if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					cmd <= cmd_backlog.pop_front();
					cmd_valid <= 1'b1;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// reply side stall, with a single long hold-off
	always @(posedge clk) begin
		if (hold_start) hold_left <= HOLD_CYCLES;
		else if (hold_left != 0) hold_left <= hold_left - 1;
		rsp_stall <= hold_start || hold_left > 1 || ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		tmse_pkg::out_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			replies_seen++;
			if (awaited_replies.size() == 0) begin
				bad_replies++;
				if (bad_replies <= 10) $display("reply word with none awaited: %h", rsp);
			end else begin
				want = awaited_replies.pop_front();
				if (rsp.status !== want.status || rsp.edge_blocked !== want.edge_blocked ||
						rsp.machine_state_out !== want.machine_state_out ||
						rsp.head_out !== want.head_out || rsp.steps_out !== want.steps_out ||
						rsp.cell_value !== want.cell_value) begin
					bad_replies++;
					if (bad_replies <= 10)
						$display({"reply mismatch (exp/got): status %0d/%0d edge %0d/%0d ",
							"state %h/%h head %0d/%0d steps %0d/%0d cell %h/%h"},
							want.status, rsp.status, want.edge_blocked, rsp.edge_blocked,
							want.machine_state_out, rsp.machine_state_out,
							want.head_out, rsp.head_out, want.steps_out, rsp.steps_out,
							want.cell_value, rsp.cell_value);
				end
			end
		end
	end

	function automatic tmse_pkg::in_t make_word(input tmse_pkg::opcode_t op);
		tmse_pkg::in_t w;
		logic [63:0]   bits;
		bits = {$urandom, $urandom};
		w = bits[$bits(tmse_pkg::in_t)-1:0];
		w.opcode = op;
		return w;
	endfunction

	function automatic tmse_pkg::in_t rule_word(input int slot, input logic [7:0] st,
			input logic [7:0] sc, input logic [7:0] wr, input logic [1:0] mv,
			input logic [7:0] nx);
		tmse_pkg::in_t w;
		w = make_word(tmse_pkg::OP_LOAD);
		w.rule_index = 6'(slot);
		w.rule_state = st;
		w.rule_scan = sc;
		w.rule_write = wr;
		w.rule_move = mv;
		w.rule_next = nx;
		return w;
	endfunction

	function automatic tmse_pkg::in_t read_word(input logic [tmse_pkg::HEAD_BITS-1:0] addr);
		tmse_pkg::in_t w;
		w = make_word(tmse_pkg::OP_READ);
		w.tape_addr = addr;
		return w;
	endfunction

	// a step never searches a slot left unwritten since reset: fill any gap first
	task automatic queue_word(input tmse_pkg::in_t w);
		tmse_pkg::in_t fill;
		int            lim;
		if (w.opcode == tmse_pkg::OP_STEP) begin
			lim = (cfg_rules_used > RULE_SLOTS) ? RULE_SLOTS : int'(cfg_rules_used);
			for (int k = 0; k < lim; k++) begin
				if (!slot_filled[k]) begin
					fill = make_word(tmse_pkg::OP_LOAD);
					fill.rule_index = 6'(k);
					slot_filled[k] = 1'b1;
					cmd_backlog.push_back(fill);
					cmds_queued++;
				end
			end
		end
		if (w.opcode == tmse_pkg::OP_LOAD) slot_filled[w.rule_index] = 1'b1;
		cmd_backlog.push_back(w);
		cmds_queued++;
	endtask

	task automatic wait_drained();
		while (replies_seen != cmds_queued) @(posedge clk);
	endtask

	task automatic apb_access(input bit wr, input logic [1:0] idx, input logic [31:0] data,
			output logic [31:0] rd);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		logic [31:0] rd;
		apb_access(1'b1, idx, val, rd);
		apb_access(1'b0, idx, '0, rd);
		if (rd !== val) begin
			bad_replies++;
			if (bad_replies <= 10)
				$display("register %0d readback: expected %h got %h", idx, val, rd);
		end
	endtask

	task automatic set_config(input logic [7:0] is, input logic [7:0] fs,
			input logic [9:0] ip, input logic [6:0] ru);
		wait_drained();
		write_reg(tmse_pkg::REG_INIT_STATE, 32'(is));
		write_reg(tmse_pkg::REG_FINAL_STATE, 32'(fs));
		write_reg(tmse_pkg::REG_INIT_POS, 32'(ip));
		write_reg(tmse_pkg::REG_RULES_USED, 32'(ru));
		cfg_init_state = is;
		cfg_final_state = fs;
		cfg_init_pos = ip;
		cfg_rules_used = ru;
	endtask

	// one machine: rule table over a small alphabet, a start, then a run of steps mixed with reads and random commands
	task automatic run_program(input int run_len);
		logic [7:0] st_pool [4];
		logic [7:0] sym_pool [4];
		int         n;
		st_pool[0] = cfg_init_state;
		st_pool[1] = cfg_init_state + 8'd1;
		st_pool[2] = 8'($urandom);
		st_pool[3] = cfg_final_state;
		sym_pool[0] = '0;
		sym_pool[1] = 8'($urandom);
		sym_pool[2] = 8'($urandom);
		sym_pool[3] = 8'($urandom);
		n = (cfg_rules_used > RULE_SLOTS) ? RULE_SLOTS : int'(cfg_rules_used);
		for (int k = 0; k < n; k++)
			queue_word(rule_word(k, st_pool[$urandom_range(2)], sym_pool[$urandom_range(3)],
				sym_pool[$urandom_range(3)], 2'($urandom_range(3)),
				st_pool[$urandom_range(3)]));
		queue_word(make_word(tmse_pkg::OP_START));
		repeat (run_len) begin
			case ($urandom_range(9))
				0: queue_word(read_word(10'(int'(cfg_init_pos) + int'($urandom_range(16)) - 8)));
				1: queue_word(make_word(tmse_pkg::opcode_t'($urandom_range(3))));
				default: queue_word(make_word(tmse_pkg::OP_STEP));
			endcase
		end
	endtask

	function automatic logic [9:0] pick_position();
		case ($urandom_range(3))
			0: return 10'($urandom_range(5));
			1: return 10'($urandom_range(1023, 1018));
			default: return 10'($urandom_range(1023));
		endcase
	endfunction

	task automatic run_phase(input int p);
		int mode;
		int runs;
		mode = p % 4;
		runs = 4;
		case (p)
			0: begin
				set_config(8'($urandom), 8'($urandom), pick_position(), 7'd127);
				runs = 2;
			end
			1: begin
				set_config(8'h00, 8'h00, 10'd0, 7'd0);
				runs = 2;
			end
			2: begin
				set_config(8'hFF, 8'hFF, 10'd1023, 7'd64);
				runs = 2;
			end
			default: set_config(8'($urandom), 8'($urandom), pick_position(),
				7'($urandom_range(12, 1)));
		endcase
		send_gap_pct = (mode == 1) ? 51 : (mode == 3) ? 28 : 0;
		stall_pct = (mode == 2) ? 51 : (mode == 3) ? 28 : 0;
		if (p == 4) begin
			@(posedge clk);
			hold_start <= 1'b1;
			@(posedge clk);
			hold_start <= 1'b0;
		end
		repeat (runs) run_program($urandom_range(40, 10));
	endtask

	initial begin
		int p;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// right edge, left move, alternate stay code, rule priority, final state
		set_config(8'hFF, 8'hAA, 10'd1023, 7'd4);
		queue_word(rule_word(0, 8'hFF, 8'h00, 8'hFF, tmse_pkg::MOVE_RIGHT, 8'hFF));
		queue_word(rule_word(1, 8'hFF, 8'hFF, 8'h55, tmse_pkg::MOVE_LEFT, 8'h00));
		queue_word(rule_word(2, 8'h00, 8'h00, 8'h01, tmse_pkg::MOVE_STAY_ALT, 8'hAA));
		queue_word(rule_word(3, 8'h00, 8'h00, 8'h02, tmse_pkg::MOVE_STAY, 8'h01));
		queue_word(make_word(tmse_pkg::OP_STEP));
		queue_word(make_word(tmse_pkg::OP_START));
		repeat (4) queue_word(make_word(tmse_pkg::OP_STEP));
		queue_word(read_word(10'd1023));
		queue_word(read_word(10'd1022));
		queue_word(read_word(10'd0));

		// left edge and a miss outside the final state
		set_config(8'h00, 8'hFF, 10'd0, 7'd1);
		queue_word(rule_word(0, 8'h00, 8'h00, 8'h80, tmse_pkg::MOVE_LEFT, 8'h00));
		queue_word(rule_word(63, 8'hFF, 8'hFF, 8'hFF, tmse_pkg::MOVE_STAY_ALT, 8'hFF));
		queue_word(make_word(tmse_pkg::OP_START));
		queue_word(make_word(tmse_pkg::OP_STEP));
		queue_word(make_word(tmse_pkg::OP_STEP));
		queue_word(read_word(10'd0));
		queue_word(read_word(10'd1023));

		p = 0;
		while (cmds_queued < 1150) begin
			run_phase(p);
			p++;
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (bad_replies == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
